@@ rtl/ptsmc_pkg.sv @@
// Shared types, constants and helper functions of the pan/tilt servo mode controller.
package ptsmc_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QSUM_W = FILL_W + 1;

  localparam int unsigned CFG_W = 10;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [7:0] ANGLE_MAX = 8'd180;
  localparam logic [7:0] ANGLE_MID = 8'd90;
  localparam logic [6:0] HALF_MAX = 7'd90;
  localparam logic [6:0] HALF_MIN = 7'd1;

  typedef enum logic [1:0] {
    MODE_SCAN     = 2'd0,
    MODE_MANUAL   = 2'd1,
    MODE_TRACKING = 2'd2,
    MODE_NONE     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ACT_SET_MODE = 2'd0,
    ACT_COMMAND  = 2'd1,
    ACT_TICK     = 2'd2,
    ACT_UNUSED   = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X   = 3'd0,
    CFG_CENTER_Y   = 3'd1,
    CFG_DEAD_ZONE  = 3'd2,
    CFG_SMALL_ZONE = 3'd3,
    CFG_SCAN_HALF  = 3'd4,
    CFG_MAN_STEP   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic              en;
    logic [QPTR_W-1:0] addr;
    logic [1:0]        cmd;
  } q_wr_t;

  // Saturates a signed angle sum to the servo range.
  function automatic logic [7:0] clamp_angle(logic signed [10:0] v);
    logic [7:0] r;
    if (v >= $signed({3'b000, ANGLE_MAX})) begin
      r = ANGLE_MAX;
    end else if (v <= 11'sd0) begin
      r = 8'd0;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  // Folds a pointer sum below twice the depth back into the queue range.
  function automatic logic [QPTR_W-1:0] qwrap(logic [QSUM_W-1:0] s);
    logic [QSUM_W-1:0] r;
    r = s;
    if (s >= QSUM_W'(QUEUE_DEPTH)) begin
      r = s - QSUM_W'(QUEUE_DEPTH);
    end
    return r[QPTR_W-1:0];
  endfunction

endpackage

@@ rtl/ptsmc_if.sv @@
// Valid/ready channel interfaces for input items and result items.
interface ptsmc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [1:0]         mode_select;
  logic [7:0]         command_byte;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;
  logic               target_missing;

  modport source (
    output valid, action, mode_select, command_byte, target_x, target_y, target_missing,
    input  ready
  );
  modport sink (
    input  valid, action, mode_select, command_byte, target_x, target_y, target_missing,
    output ready
  );
endinterface

interface ptsmc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] yaw_command;
  logic [7:0] pitch_command;
  logic       drive_strobe;
  logic [1:0] current_mode;
  logic       command_dropped;

  modport source (
    output valid, yaw_command, pitch_command, drive_strobe, current_mode, command_dropped,
    input  ready
  );
  modport sink (
    input  valid, yaw_command, pitch_command, drive_strobe, current_mode, command_dropped,
    output ready
  );
endinterface

@@ rtl/ptsmc_cmd_queue.sv @@
// Manual command store with a registered head read and write-to-read forwarding.
module ptsmc_cmd_queue (
  input  logic                          clk_i,
  input  ptsmc_pkg::q_wr_t              wr_i,
  input  logic [ptsmc_pkg::QPTR_W-1:0]  rd_addr_i,
  output logic [1:0]                    head_o
);
  import ptsmc_pkg::*;

  logic [1:0] mem_q [QUEUE_DEPTH];
  logic [1:0] head_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.cmd;
    end
    if (wr_i.en && (wr_i.addr == rd_addr_i)) begin
      head_q <= wr_i.cmd;
    end else begin
      head_q <= mem_q[rd_addr_i];
    end
  end

  assign head_o = head_q;

endmodule

@@ rtl/pan_tilt_servo_mode_controller.sv @@
// Pan/tilt servo mode controller top level with configuration registers and result register.
// The block takes one item per clock and returns exactly one result for each item, in the cycle
// after it is taken; a full result register that is not being drained holds off the next item.
// Angles, mode, sweep window and queue pointers live in registers that are updated in the cycle
// an item is taken, while the manual command queue sits in a small synchronous memory whose head
// entry is read ahead every cycle, with a written entry forwarded when it lands on the head.
module pan_tilt_servo_mode_controller (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ptsmc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ptsmc_pkg::CFG_W-1:0]       cfg_data_i,
  ptsmc_in_if.sink                          item_in,
  ptsmc_out_if.source                       item_out
);
  import ptsmc_pkg::*;

  logic [9:0] center_x_q, center_y_q, dead_zone_q, small_zone_q;
  logic [6:0] scan_half_q;
  logic [7:0] man_step_q;

  logic [7:0]        yaw_q, yaw_d, pitch_q, pitch_d;
  mode_e             mode_q, mode_d;
  logic [7:0]        upper_q, upper_d, lower_q, lower_d;
  logic              heading_q, heading_d;
  logic [QPTR_W-1:0] rd_slot_q, rd_slot_d;
  logic [FILL_W-1:0] fill_q, fill_d;

  logic       out_valid_q;
  logic [7:0] out_yaw_q, out_pitch_q;
  logic       out_strobe_q, out_drop_q;
  mode_e      out_mode_q;

  logic       accept;
  logic       strobe, dropped;
  q_wr_t      q_wr;
  logic [1:0] head;

  action_e action;
  mode_e   mode_sel;

  logic [6:0]         half;
  logic [8:0]         yaw_plus_h;
  logic [7:0]         twice_h;
  logic               new_heading;
  logic signed [10:0] step_s;
  logic signed [16:0] dx, dy;
  logic [16:0]        ax, ay;
  logic signed [10:0] yaw_s, pitch_s;

  assign item_in.ready = !out_valid_q || item_out.ready;
  assign accept = item_in.valid && item_in.ready;
  assign action = action_e'(item_in.action);
  assign mode_sel = mode_e'(item_in.mode_select);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q   <= 10'd320;
      center_y_q   <= 10'd240;
      dead_zone_q  <= 10'd100;
      small_zone_q <= 10'd50;
      scan_half_q  <= 7'd30;
      man_step_q   <= 8'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CENTER_X:   center_x_q   <= cfg_data_i;
        CFG_CENTER_Y:   center_y_q   <= cfg_data_i;
        CFG_DEAD_ZONE:  dead_zone_q  <= cfg_data_i;
        CFG_SMALL_ZONE: small_zone_q <= cfg_data_i;
        CFG_SCAN_HALF:  scan_half_q  <= cfg_data_i[6:0];
        CFG_MAN_STEP:   man_step_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    half = scan_half_q;
    if (scan_half_q < HALF_MIN) begin
      half = HALF_MIN;
    end else if (scan_half_q > HALF_MAX) begin
      half = HALF_MAX;
    end
    yaw_plus_h = {1'b0, yaw_q} + {2'b00, half};
    twice_h    = {half, 1'b0};

    new_heading = heading_q;
    if ((yaw_q >= upper_q) || (yaw_q <= lower_q)) begin
      new_heading = !heading_q;
    end

    step_s = head[0] ? -$signed({3'b000, man_step_q}) : $signed({3'b000, man_step_q});

    dx = $signed({item_in.target_x[15], item_in.target_x}) - $signed({7'b0, center_x_q});
    dy = $signed({item_in.target_y[15], item_in.target_y}) - $signed({7'b0, center_y_q});
    ax = dx[16] ? 17'(-dx) : 17'(dx);
    ay = dy[16] ? 17'(-dy) : 17'(dy);

    yaw_s   = $signed({3'b000, yaw_q});
    pitch_s = $signed({3'b000, pitch_q});
  end

  always_comb begin
    yaw_d     = yaw_q;
    pitch_d   = pitch_q;
    mode_d    = mode_q;
    upper_d   = upper_q;
    lower_d   = lower_q;
    heading_d = heading_q;
    rd_slot_d = rd_slot_q;
    fill_d    = fill_q;
    strobe    = 1'b0;
    dropped   = 1'b0;
    q_wr.en   = 1'b0;
    q_wr.addr = qwrap(QSUM_W'(rd_slot_q) + QSUM_W'(fill_q));
    q_wr.cmd  = item_in.command_byte[1:0];

    if (accept) begin
      unique case (action)
        ACT_SET_MODE: begin
          if (mode_sel != mode_q) begin
            rd_slot_d = '0;
            fill_d    = '0;
            mode_d    = mode_sel;
            if (mode_sel == MODE_SCAN) begin
              heading_d = 1'b0;
              if (yaw_plus_h >= {1'b0, ANGLE_MAX}) begin
                upper_d = ANGLE_MAX;
                lower_d = ANGLE_MAX - twice_h;
              end else if (yaw_q <= {1'b0, half}) begin
                upper_d = twice_h;
                lower_d = 8'd0;
              end else begin
                upper_d = yaw_plus_h[7:0];
                lower_d = yaw_q - {1'b0, half};
              end
            end
          end
        end
        ACT_COMMAND: begin
          if (mode_q == MODE_MANUAL) begin
            if (fill_q == FILL_W'(QUEUE_DEPTH)) begin
              dropped = 1'b1;
            end else begin
              q_wr.en = 1'b1;
              fill_d  = fill_q + FILL_W'(1);
            end
          end
        end
        ACT_TICK: begin
          strobe = 1'b1;
          unique case (mode_q)
            MODE_SCAN: begin
              heading_d = new_heading;
              yaw_d = clamp_angle(new_heading ? yaw_s - 11'sd1 : yaw_s + 11'sd1);
            end
            MODE_MANUAL: begin
              if (fill_q != '0) begin
                rd_slot_d = qwrap(QSUM_W'(rd_slot_q) + QSUM_W'(1));
                fill_d    = fill_q - FILL_W'(1);
                if (head[1]) begin
                  pitch_d = clamp_angle(pitch_s + step_s);
                end else begin
                  yaw_d = clamp_angle(yaw_s + step_s);
                end
              end
            end
            MODE_TRACKING: begin
              if (!item_in.target_missing) begin
                if (ax > {7'b0, dead_zone_q}) begin
                  if (ax <= {7'b0, small_zone_q}) begin
                    yaw_d = clamp_angle(dx[16] ? yaw_s + 11'sd1 : yaw_s - 11'sd1);
                  end else begin
                    yaw_d = clamp_angle(dx[16] ? yaw_s + 11'sd2 : yaw_s - 11'sd2);
                  end
                end
                if (ay > {7'b0, dead_zone_q}) begin
                  pitch_d = clamp_angle((!dy[16] && (dy != '0)) ? pitch_s + 11'sd1
                                                                : pitch_s - 11'sd1);
                end
              end
            end
            MODE_NONE: ;
          endcase
        end
        ACT_UNUSED: ;
      endcase
    end
  end

  ptsmc_cmd_queue u_queue (
    .clk_i     (clk_i),
    .wr_i      (q_wr),
    .rd_addr_i (rd_slot_d),
    .head_o    (head)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_q       <= ANGLE_MID;
      pitch_q     <= ANGLE_MID;
      mode_q      <= MODE_NONE;
      upper_q     <= 8'd0;
      lower_q     <= 8'd0;
      heading_q   <= 1'b0;
      rd_slot_q   <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      yaw_q     <= yaw_d;
      pitch_q   <= pitch_d;
      mode_q    <= mode_d;
      upper_q   <= upper_d;
      lower_q   <= lower_d;
      heading_q <= heading_d;
      rd_slot_q <= rd_slot_d;
      fill_q    <= fill_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (item_out.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_yaw_q    <= yaw_d;
      out_pitch_q  <= pitch_d;
      out_strobe_q <= strobe;
      out_mode_q   <= mode_d;
      out_drop_q   <= dropped;
    end
  end

  assign item_out.valid           = out_valid_q;
  assign item_out.yaw_command     = out_yaw_q;
  assign item_out.pitch_command   = out_pitch_q;
  assign item_out.drive_strobe    = out_strobe_q;
  assign item_out.current_mode    = out_mode_q;
  assign item_out.command_dropped = out_drop_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(QUEUE_DEPTH))
    else $error("Queue fill count exceeds the queue depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (yaw_q <= ANGLE_MAX) && (pitch_q <= ANGLE_MAX))
    else $error("Servo angle left the 0 to 180 degree range.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (action == ACT_SET_MODE) && (mode_sel != mode_q)) |=>
      ((fill_q == '0) && (rd_slot_q == '0)))
    else $error("Queue not cleared on a mode change.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_out.valid && item_out.command_dropped) |->
      ((out_mode_q == MODE_MANUAL) && !item_out.drive_strobe))
    else $error("Dropped command reported outside manual mode.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (action == ACT_TICK) && (mode_q != MODE_MANUAL)) |=>
      (fill_q == $past(fill_q)))
    else $error("Queue count changed on a tick outside manual mode.");

endmodule
